>>> rtl/tmsc_pkg.sv
// Types, codes and helpers shared by the timed motion safety controller.
// No dependencies; every other file refers here by scoped name.
package tmsc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned DurW  = 16;
    localparam int unsigned PctW  = 8;
    localparam int unsigned MaxW  = 7;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [MaxW-1:0] MagLimit = 7'd100;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SKILL  = 2'd1,
        OP_HEALTH = 2'd2,
        OP_BENCH  = 2'd3
    } op_t;

    localparam logic [2:0] SK_STOP     = 3'd0;
    localparam logic [2:0] SK_RELEASE  = 3'd1;
    localparam logic [2:0] SK_APPROACH = 3'd2;
    localparam logic [2:0] SK_TURN     = 3'd3;
    localparam logic [2:0] SK_INVITE   = 3'd4;

    localparam logic [2:0] CS_NONE     = 3'd0;
    localparam logic [2:0] CS_APPROACH = 3'd1;
    localparam logic [2:0] CS_TURN     = 3'd2;
    localparam logic [2:0] CS_INVITE   = 3'd3;
    localparam logic [2:0] CS_BENCH    = 3'd4;

    typedef enum logic [1:0] {
        ST_STOPPED  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_NONE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        RS_STOP_APPLIED      = 4'd0,
        RS_RELEASE_APPLIED   = 4'd1,
        RS_STOP_NO_SERVO     = 4'd2,
        RS_MOTOR_FAULT       = 4'd3,
        RS_SENSORS_DOWN      = 4'd4,
        RS_MOTION_ACCEPTED   = 4'd5,
        RS_SERVO_DOWN        = 4'd6,
        RS_SKILL_UNSUPPORTED = 4'd7,
        RS_BENCH_ACCEPTED    = 4'd8,
        RS_BENCH_REJECTED    = 4'd9,
        RS_NONE              = 4'd10
    } reason_t;

    typedef enum logic [1:0] {
        MODE_COAST = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_BRAKE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SERVO_NONE    = 2'd0,
        SERVO_RELEASE = 2'd1,
        SERVO_INVITE  = 2'd2
    } servo_t;

    typedef enum logic [1:0] {
        SAFE_FAULT   = 2'd0,
        SAFE_READY   = 2'd1,
        SAFE_STOPPED = 2'd2
    } safety_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_MOTOR  = 3'd0,
        CFG_BRAKE_TIME = 3'd1,
        CFG_APPROACH   = 3'd2,
        CFG_TURN       = 3'd3,
        CFG_HEARTBEAT  = 3'd4,
        CFG_BENCH_MAX  = 3'd5,
        CFG_MODE_FLAGS = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        op_t                    operation;
        logic [2:0]             skill;
        logic [TimeW-1:0]       now_ms;
        logic                   sensors_healthy;
        logic                   motor_driver_ready;
        logic                   servo_ready;
        logic signed [PctW-1:0] left_percent;
        logic signed [PctW-1:0] right_percent;
        logic [DurW-1:0]        duration_ms;
    } item_t;

    typedef struct packed {
        logic [MaxW-1:0] max_motor_percent;
        logic [DurW-1:0] brake_time_ms;
        logic [DurW-1:0] approach_time_ms;
        logic [DurW-1:0] turn_time_ms;
        logic [DurW-1:0] heartbeat_timeout_ms;
        logic [DurW-1:0] bench_max_ms;
        logic [1:0]      mode_flags;
    } cfg_t;

    typedef struct packed {
        status_t                status;
        reason_t                reason;
        mode_t                  motor_mode;
        logic signed [PctW-1:0] left_drive;
        logic signed [PctW-1:0] right_drive;
        servo_t                 servo_command;
        logic [2:0]             current_skill;
        safety_t                safety_state;
    } result_t;

    function automatic logic reached(input logic [TimeW-1:0] now_ms,
                                     input logic [TimeW-1:0] deadline);
        logic [TimeW-1:0] diff;
        diff = now_ms - deadline;
        return !diff[TimeW-1];
    endfunction

endpackage

>>> rtl/tmsc_cfg.sv
// Configuration register file of the timed motion safety controller.
// Depends on tmsc_pkg for register indexes and the cfg_t bundle.
module tmsc_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmsc_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [tmsc_pkg::CfgDataW-1:0]    cfg_data,
    output tmsc_pkg::cfg_t                   cfg
);

    tmsc_pkg::cfg_t cfg_reg;
    tmsc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tmsc_pkg::CFG_MAX_MOTOR:
                    cfg_next.max_motor_percent = cfg_data[tmsc_pkg::MaxW-1:0];
                tmsc_pkg::CFG_BRAKE_TIME: cfg_next.brake_time_ms        = cfg_data;
                tmsc_pkg::CFG_APPROACH:   cfg_next.approach_time_ms     = cfg_data;
                tmsc_pkg::CFG_TURN:       cfg_next.turn_time_ms         = cfg_data;
                tmsc_pkg::CFG_HEARTBEAT:  cfg_next.heartbeat_timeout_ms = cfg_data;
                tmsc_pkg::CFG_BENCH_MAX:  cfg_next.bench_max_ms         = cfg_data;
                tmsc_pkg::CFG_MODE_FLAGS: cfg_next.mode_flags           = cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_motor_percent    <= 7'd100;
            cfg_reg.brake_time_ms        <= 16'd200;
            cfg_reg.approach_time_ms     <= 16'd1500;
            cfg_reg.turn_time_ms         <= 16'd800;
            cfg_reg.heartbeat_timeout_ms <= 16'd1000;
            cfg_reg.bench_max_ms         <= 16'd3000;
            cfg_reg.mode_flags           <= 2'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/tmsc_core.sv
// Controller state and the combinational step logic for one item.
// Depends on tmsc_pkg for item, configuration and result types.
module tmsc_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  tmsc_pkg::item_t    item,
    input  tmsc_pkg::cfg_t     cfg,
    output tmsc_pkg::result_t  res
);

    logic [2:0]                       skill_reg, skill_next;
    logic                             driving_reg, driving_next;
    logic                             braking_reg, braking_next;
    logic                             fault_reg, fault_next;
    logic                             sensors_reg, sensors_next;
    logic [tmsc_pkg::TimeW-1:0]       motion_dl_reg, motion_dl_next;
    logic [tmsc_pkg::TimeW-1:0]       heart_dl_reg, heart_dl_next;
    logic [tmsc_pkg::TimeW-1:0]       brake_dl_reg, brake_dl_next;
    logic signed [tmsc_pkg::PctW-1:0] left_lvl_reg, left_lvl_next;
    logic signed [tmsc_pkg::PctW-1:0] right_lvl_reg, right_lvl_next;

    logic [tmsc_pkg::MaxW-1:0]        mag;
    logic [tmsc_pkg::PctW-1:0]        mag8, neg_mag8;
    logic signed [tmsc_pkg::PctW:0]   mag_pos, mag_neg, l9, r9;
    logic                             bench_ok;
    logic                             stop_req, start_req, invite_ok;
    logic [2:0]                       start_skill;
    logic [tmsc_pkg::PctW-1:0]        start_left, start_right;
    logic [tmsc_pkg::DurW-1:0]        start_dur;

    assign mag      = (cfg.max_motor_percent > tmsc_pkg::MagLimit) ?
                      tmsc_pkg::MagLimit : cfg.max_motor_percent;
    assign mag8     = {1'b0, mag};
    assign neg_mag8 = ~mag8 + 8'd1;
    assign mag_pos  = signed'({2'b00, mag});
    assign mag_neg  = -mag_pos;
    assign l9       = {item.left_percent[tmsc_pkg::PctW-1], item.left_percent};
    assign r9       = {item.right_percent[tmsc_pkg::PctW-1], item.right_percent};

    assign bench_ok = cfg.mode_flags[1] && !fault_reg && item.motor_driver_ready &&
                      (item.duration_ms != '0) && (item.duration_ms <= cfg.bench_max_ms) &&
                      (l9 <= mag_pos) && (l9 >= mag_neg) &&
                      (r9 <= mag_pos) && (r9 >= mag_neg);

    always_comb begin
        skill_next     = skill_reg;
        driving_next   = driving_reg;
        braking_next   = braking_reg;
        fault_next     = fault_reg;
        sensors_next   = sensors_reg;
        motion_dl_next = motion_dl_reg;
        heart_dl_next  = heart_dl_reg;
        brake_dl_next  = brake_dl_reg;
        left_lvl_next  = left_lvl_reg;
        right_lvl_next = right_lvl_reg;

        stop_req    = 1'b0;
        start_req   = 1'b0;
        invite_ok   = 1'b0;
        start_skill = tmsc_pkg::CS_NONE;
        start_left  = '0;
        start_right = '0;
        start_dur   = '0;

        res.status        = tmsc_pkg::ST_NONE;
        res.reason        = tmsc_pkg::RS_NONE;
        res.servo_command = tmsc_pkg::SERVO_NONE;

        unique case (item.operation)
            tmsc_pkg::OP_TICK: begin
                if (braking_reg && tmsc_pkg::reached(item.now_ms, brake_dl_reg)) begin
                    braking_next = 1'b0;
                end
                if (driving_reg && (tmsc_pkg::reached(item.now_ms, motion_dl_reg) ||
                                    tmsc_pkg::reached(item.now_ms, heart_dl_reg))) begin
                    stop_req = 1'b1;
                end
            end
            tmsc_pkg::OP_HEALTH: begin
                sensors_next = item.sensors_healthy;
                stop_req     = !item.sensors_healthy && driving_reg;
            end
            tmsc_pkg::OP_SKILL: begin
                priority if (item.skill == tmsc_pkg::SK_STOP) begin
                    stop_req   = 1'b1;
                    res.status = tmsc_pkg::ST_STOPPED;
                    res.reason = tmsc_pkg::RS_STOP_APPLIED;
                end else if (item.skill == tmsc_pkg::SK_RELEASE) begin
                    stop_req   = 1'b1;
                    res.status = tmsc_pkg::ST_STOPPED;
                    if (item.servo_ready) begin
                        res.servo_command = tmsc_pkg::SERVO_RELEASE;
                        res.reason        = tmsc_pkg::RS_RELEASE_APPLIED;
                    end else begin
                        res.reason = tmsc_pkg::RS_STOP_NO_SERVO;
                    end
                end else if (fault_reg || !item.motor_driver_ready) begin
                    res.status = tmsc_pkg::ST_REJECTED;
                    res.reason = tmsc_pkg::RS_MOTOR_FAULT;
                end else if (!sensors_reg && !cfg.mode_flags[0]) begin
                    res.status = tmsc_pkg::ST_REJECTED;
                    res.reason = tmsc_pkg::RS_SENSORS_DOWN;
                end else if (item.skill == tmsc_pkg::SK_APPROACH) begin
                    start_req   = 1'b1;
                    start_skill = tmsc_pkg::CS_APPROACH;
                    start_left  = mag8;
                    start_right = mag8;
                    start_dur   = cfg.approach_time_ms;
                    res.status  = tmsc_pkg::ST_ACCEPTED;
                    res.reason  = tmsc_pkg::RS_MOTION_ACCEPTED;
                end else if (item.skill == tmsc_pkg::SK_TURN) begin
                    start_req   = 1'b1;
                    start_skill = tmsc_pkg::CS_TURN;
                    start_left  = mag8;
                    start_right = neg_mag8;
                    start_dur   = cfg.turn_time_ms;
                    res.status  = tmsc_pkg::ST_ACCEPTED;
                    res.reason  = tmsc_pkg::RS_MOTION_ACCEPTED;
                end else if (item.skill == tmsc_pkg::SK_INVITE) begin
                    stop_req = 1'b1;
                    if (item.servo_ready) begin
                        invite_ok         = 1'b1;
                        res.servo_command = tmsc_pkg::SERVO_INVITE;
                        res.status        = tmsc_pkg::ST_ACCEPTED;
                        res.reason        = tmsc_pkg::RS_MOTION_ACCEPTED;
                    end else begin
                        res.status = tmsc_pkg::ST_REJECTED;
                        res.reason = tmsc_pkg::RS_SERVO_DOWN;
                    end
                end else begin
                    res.status = tmsc_pkg::ST_REJECTED;
                    res.reason = tmsc_pkg::RS_SKILL_UNSUPPORTED;
                end
            end
            tmsc_pkg::OP_BENCH: begin
                if (bench_ok) begin
                    start_req   = 1'b1;
                    start_skill = tmsc_pkg::CS_BENCH;
                    start_left  = item.left_percent;
                    start_right = item.right_percent;
                    start_dur   = item.duration_ms;
                    res.status  = tmsc_pkg::ST_ACCEPTED;
                    res.reason  = tmsc_pkg::RS_BENCH_ACCEPTED;
                end else begin
                    res.status = tmsc_pkg::ST_REJECTED;
                    res.reason = tmsc_pkg::RS_BENCH_REJECTED;
                end
            end
            default: begin
            end
        endcase

        if (stop_req) begin
            skill_next     = tmsc_pkg::CS_NONE;
            driving_next   = 1'b0;
            left_lvl_next  = '0;
            right_lvl_next = '0;
            motion_dl_next = '0;
            heart_dl_next  = '0;
            if (!item.motor_driver_ready) begin
                fault_next = 1'b1;
            end else begin
                braking_next  = 1'b1;
                brake_dl_next = item.now_ms + {16'd0, cfg.brake_time_ms};
            end
        end
        if (invite_ok) begin
            skill_next = tmsc_pkg::CS_INVITE;
        end
        if (start_req) begin
            braking_next   = 1'b0;
            left_lvl_next  = start_left;
            right_lvl_next = start_right;
            skill_next     = start_skill;
            driving_next   = 1'b1;
            motion_dl_next = item.now_ms + {16'd0, start_dur};
            heart_dl_next  = item.now_ms + {16'd0, cfg.heartbeat_timeout_ms};
        end

        priority if (braking_next) begin
            res.motor_mode = tmsc_pkg::MODE_BRAKE;
        end else if (driving_next) begin
            res.motor_mode = tmsc_pkg::MODE_DRIVE;
        end else begin
            res.motor_mode = tmsc_pkg::MODE_COAST;
        end
        res.left_drive  = (res.motor_mode == tmsc_pkg::MODE_DRIVE) ? left_lvl_next  : '0;
        res.right_drive = (res.motor_mode == tmsc_pkg::MODE_DRIVE) ? right_lvl_next : '0;
        res.current_skill = skill_next;
        priority if (fault_next) begin
            res.safety_state = tmsc_pkg::SAFE_FAULT;
        end else if (driving_next || sensors_next) begin
            res.safety_state = tmsc_pkg::SAFE_READY;
        end else begin
            res.safety_state = tmsc_pkg::SAFE_STOPPED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skill_reg     <= tmsc_pkg::CS_NONE;
            driving_reg   <= 1'b0;
            braking_reg   <= 1'b0;
            fault_reg     <= 1'b0;
            sensors_reg   <= 1'b0;
            motion_dl_reg <= '0;
            heart_dl_reg  <= '0;
            brake_dl_reg  <= '0;
            left_lvl_reg  <= '0;
            right_lvl_reg <= '0;
        end else if (advance) begin
            skill_reg     <= skill_next;
            driving_reg   <= driving_next;
            braking_reg   <= braking_next;
            fault_reg     <= fault_next;
            sensors_reg   <= sensors_next;
            motion_dl_reg <= motion_dl_next;
            heart_dl_reg  <= heart_dl_next;
            brake_dl_reg  <= brake_dl_next;
            left_lvl_reg  <= left_lvl_next;
            right_lvl_reg <= right_lvl_next;
        end
    end

endmodule

>>> rtl/timed_motion_safety_controller.sv
// Timed motion safety controller: takes one item per clock cycle at full rate while
// the result is not stalled, and returns exactly one result item for each. An accepted
// item is held in the input register. From there it passes the step logic of tmsc_core,
// which updates the controller state, and it is written to the result register as it
// leaves the input register. A stalled result holds the input register and backs up
// the input behind it. The combinational state update sets the rate.
// Depends on tmsc_pkg, tmsc_cfg and tmsc_core.
module timed_motion_safety_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // skill[2:0], now_ms[34:3], sensors_healthy[35], motor_driver_ready[36],
    // servo_ready[37], left_percent[45:38], right_percent[53:46],
    // duration_ms[69:54], zero[71:70]
    input  logic [71:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reason[3:0], motor_mode[5:4], left_drive[13:6], right_drive[21:14],
    // servo_command[23:22], current_skill[26:24], safety_state[28:27], zero[31:29]
    output logic [31:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic              in_valid_reg, in_valid_next;
    tmsc_pkg::item_t   in_item_reg;
    logic              out_valid_reg, out_valid_next;
    tmsc_pkg::result_t out_res_reg;
    tmsc_pkg::result_t core_res;
    tmsc_pkg::cfg_t    cfg;
    tmsc_pkg::item_t   s_item;
    logic              advance;
    logic              s_take;

    tmsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_item.operation          = tmsc_pkg::op_t'(s_tuser);
    assign s_item.skill              = s_tdata[2:0];
    assign s_item.now_ms             = s_tdata[34:3];
    assign s_item.sensors_healthy    = s_tdata[35];
    assign s_item.motor_driver_ready = s_tdata[36];
    assign s_item.servo_ready        = s_tdata[37];
    assign s_item.left_percent       = s_tdata[45:38];
    assign s_item.right_percent      = s_tdata[53:46];
    assign s_item.duration_ms        = s_tdata[69:54];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    tmsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {3'b000,
                       out_res_reg.safety_state,
                       out_res_reg.current_skill,
                       out_res_reg.servo_command,
                       out_res_reg.right_drive,
                       out_res_reg.left_drive,
                       out_res_reg.motor_mode,
                       out_res_reg.reason};

    a_drive_is_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_res_reg.motor_mode == tmsc_pkg::MODE_DRIVE)
        |-> (out_res_reg.safety_state == tmsc_pkg::SAFE_READY))
        else $error("driving result without ready safety state");

    a_idle_levels_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_res_reg.motor_mode != tmsc_pkg::MODE_DRIVE)
        |-> (out_res_reg.left_drive == '0) && (out_res_reg.right_drive == '0))
        else $error("drive levels shown while not driving");

    a_bench_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_res_reg.reason == tmsc_pkg::RS_BENCH_ACCEPTED)
        |-> (out_res_reg.current_skill == tmsc_pkg::CS_BENCH) &&
            (out_res_reg.motor_mode == tmsc_pkg::MODE_DRIVE))
        else $error("accepted bench run not driving");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed item lost before result register");

endmodule
